@@ rtl/mrp_pkg.sv @@
// Package for the MIPS relocation patcher: codes, result type and defaults.
// Used by mips_relocation_patcher_top; depends on nothing else.
package mrp_pkg;

    // Default number of HI16 pair registers.
    localparam int PAIR_REGS_DEF = 32;

    // Widths of the fixed fields.
    localparam int WORD_W   = 32;
    localparam int OFFS_W   = 24;
    localparam int HALF_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Section codes from bits 31:30 of the relocation word.
    localparam logic [1:0] SEC_END    = 2'd0;
    localparam logic [1:0] SEC_TEXT   = 2'd1;
    localparam logic [1:0] SEC_DATA   = 2'd2;
    localparam logic [1:0] SEC_RODATA = 2'd3;

    // Relocation types from bits 29:24.
    localparam logic [5:0] RT_MIPS_32   = 6'd2;
    localparam logic [5:0] RT_MIPS_26   = 6'd4;
    localparam logic [5:0] RT_MIPS_HI16 = 6'd5;
    localparam logic [5:0] RT_MIPS_LO16 = 6'd6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD_ADDRESS = 2'd0,
        CFG_RELOC_OFFSET = 2'd1,
        CFG_TEXT_SIZE    = 2'd2,
        CFG_DATA_SIZE    = 2'd3
    } cfg_index_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_END     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] write_address;
        logic [WORD_W-1:0] write_data;
        logic              write_valid;
        status_t           status;
        logic              last;
    } mrp_result_t;

endpackage

@@ rtl/mips_relocation_patcher_top.sv @@
// Top level of the MIPS relocation patcher: input register, patch logic,
// HI16 pair table and a two-entry result queue. Depends on mrp_pkg.
//
// Channel   Handshake               Payload
// -------   ---------------------   -------------------------------------------
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
// in        in_valid / in_ready     reloc_word, target_word, new_segment
// out       out_valid / out_ready   write_address, write_data, write_valid,
//                                   status, last
//
// A request is registered in the input register on acceptance; the patch logic
// then writes its results into the result queue registers, from which the first
// result is offered. A full queue holds the request in the input register.
// Items with one result sustain one request per cycle while out_ready is high;
// an LO16 produces two results and fires only when the two-entry result queue,
// drained one result per cycle, is empty after its pop.
// Reset clears the control state, the stopped flag and the configuration; the
// HI16 pair table is not reset and needs no clearing pass.
// A stalled output fills the queue and then holds the input register, which in
// turn drops in_ready; nothing is lost or repeated. cfg_ready is always high.
module mips_relocation_patcher_top #(
    parameter int PAIR_REGS = mrp_pkg::PAIR_REGS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrp_pkg::WORD_W-1:0]       cfg_data,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mrp_pkg::WORD_W-1:0]       reloc_word,
    input  logic [mrp_pkg::WORD_W-1:0]       target_word,
    input  logic                             new_segment,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mrp_pkg::WORD_W-1:0]       write_address,
    output logic [mrp_pkg::WORD_W-1:0]       write_data,
    output logic                             write_valid,
    output logic [1:0]                       status,
    output logic                             last
);
    import mrp_pkg::*;

    localparam int IDX_W = $clog2(PAIR_REGS);

    // ------------------------------------------------------------------
    // Configuration registers. The section bases are kept registered so the
    // patch path needs only one add for the target address.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] load_address_reg;
    logic [WORD_W-1:0] reloc_offset_reg;
    logic [OFFS_W-1:0] text_size_reg;
    logic [OFFS_W-1:0] data_size_reg;
    logic [WORD_W-1:0] data_base_reg;
    logic [WORD_W-1:0] rodata_base_reg;
    logic [WORD_W-1:0] load_address_next;
    logic [WORD_W-1:0] reloc_offset_next;
    logic [OFFS_W-1:0] text_size_next;
    logic [OFFS_W-1:0] data_size_next;
    logic [WORD_W-1:0] data_base_next;
    logic [WORD_W-1:0] rodata_base_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        load_address_next = load_address_reg;
        reloc_offset_next = reloc_offset_reg;
        text_size_next    = text_size_reg;
        data_size_next    = data_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOAD_ADDRESS: load_address_next = cfg_data;
                CFG_RELOC_OFFSET: reloc_offset_next = cfg_data;
                CFG_TEXT_SIZE:    text_size_next    = cfg_data[OFFS_W-1:0];
                CFG_DATA_SIZE:    data_size_next    = cfg_data[OFFS_W-1:0];
                default:          ;
            endcase
        end
    end

    // The bases are computed from the new register values, so they are loaded
    // at the same edge as the register write and are valid right after it.
    assign data_base_next   = load_address_next
                            + {{(WORD_W-OFFS_W){1'b0}}, text_size_next};
    assign rodata_base_next = data_base_next + {{(WORD_W-OFFS_W){1'b0}}, data_size_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_address_reg <= '0;
            reloc_offset_reg <= '0;
            text_size_reg    <= '0;
            data_size_reg    <= '0;
            data_base_reg    <= '0;
            rodata_base_reg  <= '0;
        end
        else
        begin
            load_address_reg <= load_address_next;
            reloc_offset_reg <= reloc_offset_next;
            text_size_reg    <= text_size_next;
            data_size_reg    <= data_size_next;
            data_base_reg    <= data_base_next;
            rodata_base_reg  <= rodata_base_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic              stg_valid_reg;
    logic [WORD_W-1:0] stg_reloc_reg;
    logic [WORD_W-1:0] stg_target_reg;
    logic              stg_new_seg_reg;
    logic              stg_fire;
    logic              in_accept;

    assign in_ready  = !stg_valid_reg || stg_fire;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stg_reloc_reg   <= reloc_word;
            stg_target_reg  <= target_word;
            stg_new_seg_reg <= new_segment;
        end
    end

    // ------------------------------------------------------------------
    // HI16 pair table: address, immediate and upper half of the last HI16
    // seen for each register. Undefined until written.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] hi_address_reg    [PAIR_REGS];
    logic [HALF_W-1:0] hi_value_reg      [PAIR_REGS];
    logic [HALF_W-1:0] hi_word_upper_reg [PAIR_REGS];
    logic              hi_we;
    logic [IDX_W-1:0]  hi_wr_idx;
    logic [IDX_W-1:0]  hi_rd_idx;

    // ------------------------------------------------------------------
    // Patch logic.
    // ------------------------------------------------------------------
    logic              stopped_reg;
    logic              stopped_next;
    logic              eff_stopped;
    logic              stop_set;
    logic [1:0]        sec;
    logic [5:0]        rtype;
    logic [WORD_W-1:0] sec_base;
    logic [WORD_W-1:0] tgt_addr;
    logic [WORD_W-1:0] r26_sum;
    logic [WORD_W-1:0] lo_sext;
    logic [WORD_W-1:0] lo_full;
    logic [HALF_W-1:0] lo_hi_half;
    mrp_result_t       res0;
    mrp_result_t       res1;
    logic              two_res;

    assign sec       = stg_reloc_reg[31:30];
    assign rtype     = stg_reloc_reg[29:24];
    assign hi_wr_idx = stg_target_reg[16 +: IDX_W];
    assign hi_rd_idx = stg_target_reg[21 +: IDX_W];

    always_comb
    begin
        case (sec)
            SEC_DATA:   sec_base = data_base_reg;
            SEC_RODATA: sec_base = rodata_base_reg;
            default:    sec_base = load_address_reg;
        endcase
    end

    assign tgt_addr = sec_base + {{(WORD_W-OFFS_W){1'b0}}, stg_reloc_reg[OFFS_W-1:0]};

    // Jump patch: the 26-bit jump field is a word index inside a 256 MB region.
    assign r26_sum = {stg_target_reg[29:0], 2'b00} + reloc_offset_reg;

    // LO16: recombine with the recorded HI16 and round the low half's sign
    // back into the high half.
    assign lo_sext    = {{HALF_W{stg_target_reg[15]}}, stg_target_reg[15:0]};
    assign lo_full    = {hi_value_reg[hi_rd_idx], {HALF_W{1'b0}}} + lo_sext + reloc_offset_reg;
    assign lo_hi_half = lo_full[31:16] + {{(HALF_W-1){1'b0}}, lo_full[15]};

    assign eff_stopped = stopped_reg && !stg_new_seg_reg;

    always_comb
    begin
        res0        = '0;
        res0.last   = 1'b1;
        res0.status = ST_OK;
        res1        = '0;
        res1.last   = 1'b1;
        res1.status = ST_OK;
        two_res     = 1'b0;
        hi_we       = 1'b0;
        stop_set    = 1'b0;
        if (eff_stopped)
        begin
            res0.status = ST_IGNORED;
        end
        else if (sec == SEC_END)
        begin
            res0.status = ST_END;
            stop_set    = 1'b1;
        end
        else
        begin
            case (rtype)
                RT_MIPS_32:
                begin
                    res0.write_address = tgt_addr;
                    res0.write_data    = stg_target_reg + reloc_offset_reg;
                    res0.write_valid   = 1'b1;
                end
                RT_MIPS_26:
                begin
                    res0.write_address = tgt_addr;
                    res0.write_data    = {stg_target_reg[31:26], r26_sum[27:2]};
                    res0.write_valid   = 1'b1;
                end
                RT_MIPS_HI16:
                begin
                    hi_we = 1'b1;
                end
                RT_MIPS_LO16:
                begin
                    two_res            = 1'b1;
                    res0.write_address = hi_address_reg[hi_rd_idx];
                    res0.write_data    = {hi_word_upper_reg[hi_rd_idx], lo_hi_half};
                    res0.write_valid   = 1'b1;
                    res0.last          = 1'b0;
                    res1.write_address = tgt_addr;
                    res1.write_data    = {stg_target_reg[31:16], lo_full[15:0]};
                    res1.write_valid   = 1'b1;
                end
                default:
                begin
                    res0.status = ST_UNKNOWN;
                    stop_set    = 1'b1;
                end
            endcase
        end
    end

    assign stopped_next = stg_fire ? (eff_stopped || stop_set) : stopped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else
        begin
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire && hi_we)
        begin
            hi_address_reg[hi_wr_idx]    <= tgt_addr;
            hi_value_reg[hi_wr_idx]      <= stg_target_reg[15:0];
            hi_word_upper_reg[hi_wr_idx] <= stg_target_reg[31:16];
        end
    end

    // ------------------------------------------------------------------
    // Two-entry result queue; the head is always entry 0.
    // ------------------------------------------------------------------
    mrp_result_t q_reg [2];
    mrp_result_t q_next [2];
    logic [1:0]  q_count_reg;
    logic [1:0]  q_count_next;
    logic [1:0]  q_count_popped;
    logic        q_pop;
    logic        q_room;

    assign q_pop          = out_valid && out_ready;
    assign q_count_popped = q_count_reg - {1'b0, q_pop};
    assign q_room         = two_res ? (q_count_popped == 2'd0) : (q_count_popped <= 2'd1);
    assign stg_fire       = stg_valid_reg && q_room;

    always_comb
    begin
        q_next[0]    = q_pop ? q_reg[1] : q_reg[0];
        q_next[1]    = q_reg[1];
        q_count_next = q_count_popped;
        if (stg_fire)
        begin
            if (q_count_popped == 2'd0)
            begin
                q_next[0] = res0;
                q_next[1] = res1;
            end
            else
            begin
                q_next[1] = res0;
            end
            q_count_next = q_count_popped + (two_res ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign out_valid     = (q_count_reg != 2'd0);
    assign write_address = q_reg[0].write_address;
    assign write_data    = q_reg[0].write_data;
    assign write_valid   = q_reg[0].write_valid;
    assign status        = q_reg[0].status;
    assign last          = q_reg[0].last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (out_valid && write_valid))
        else $error("second write of an LO16 pair missing");

    a_nowrite_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_valid) |-> (last && write_address == '0 && write_data == '0))
        else $error("result without write is not a clean final result");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !stg_fire) |=> (stg_valid_reg && $stable(stg_reloc_reg)))
        else $error("input register changed while stalled");

endmodule
